### sv/hne_pkg.sv
// ----------------------------------------------------------------------------
// hne_pkg
// Shared widths, register codes and types of the heightmap normal estimator.
// ----------------------------------------------------------------------------
package hne_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PIX_W       = 32;
    localparam int SCALE_W     = 16;
    localparam int DIM_W       = 13;
    localparam int BPP_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUT_W       = 16;
    localparam int CMP_W       = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int MAX_BYTES   = 4;

    localparam int BSUM_W      = 10;
    localparam int DIFF_W      = 11;
    localparam int PLANE_W     = 18;
    localparam int HGT_W       = 28;

    localparam int VEC_W       = 35;
    localparam int UNIT_W      = 32;
    localparam int SUM_W       = 34;
    localparam int POS_W       = 6;
    localparam int NRM_W       = 20;
    localparam int SQ_W        = 40;
    localparam int N2_W        = 42;
    localparam int RAD_SHIFT   = 20;
    localparam int RAD_W       = 62;
    localparam int RES_W       = 63;
    localparam int ROOT_W      = 32;
    localparam int NUM_W       = 61;
    localparam int Q_W         = 31;
    localparam int UNIT_FRAC   = 30;
    localparam int OUT_FRAC    = 14;
    localparam int SHIFT_HI    = UNIT_FRAC + 10;
    localparam int SHIFT_LO    = OUT_FRAC + 10;

    localparam int SQRT_STEPS  = 31;
    localparam int SQRT_STAGES = (SQRT_STEPS + 1) / 2;
    localparam int DIV_STEPS   = Q_W;
    localparam int DIV_STAGES  = (DIV_STEPS + 1) / 2;

    localparam logic signed [OUT_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [OUT_W-1:0] NEG_ONE_Q14 = -16'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_SCALE     = 3'd0,
        REG_HEIGHT_SCALE    = 3'd1,
        REG_MAP_WIDTH       = 3'd2,
        REG_MAP_HEIGHT      = 3'd3,
        REG_BYTES_PER_PIXEL = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic force_up;
        logic border;
    } tag_t;

    typedef logic [2:0][VEC_W-1:0]  vec3_t;
    typedef logic [2:0][UNIT_W-1:0] unit3_t;
    typedef logic [2:0][NRM_W-1:0]  nrm3_t;

    typedef struct packed {
        tag_t       tag;
        logic [2:0] neg;
        logic       zero;
    } side_t;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic             border;
    } result_t;

endpackage

### sv/hne_unit_vec.sv
// ----------------------------------------------------------------------------
// hne_unit_vec
// Pipelined vector normalizer: range shift, sum of squares, digit-serial
// square root and three restoring dividers, two digits per stage.
// ----------------------------------------------------------------------------
module hne_unit_vec
    import hne_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   frac_hi,
    input  logic   in_valid,
    input  tag_t   in_tag,
    input  vec3_t  in_vec,
    output logic   out_valid,
    output tag_t   out_tag,
    output unit3_t out_vec
);

    typedef struct packed {
        logic [RAD_W-1:0] n;
        logic [RES_W-1:0] res;
    } sq_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [Q_W-1:0]    sr;
    } dv_t;

    function automatic sq_t sqrt_step(input sq_t cur, input int j);
        sq_t              nxt;
        logic [RES_W-1:0] bitv;
        logic [RES_W-1:0] trial;
        bitv  = RES_W'(1) << (2 * j);
        trial = cur.res + bitv;
        nxt   = cur;
        if ({1'b0, cur.n} >= trial) begin
            nxt.n   = RAD_W'({1'b0, cur.n} - trial);
            nxt.res = (cur.res >> 1) + bitv;
        end else begin
            nxt.res = cur.res >> 1;
        end
        return nxt;
    endfunction

    function automatic dv_t div_step(input dv_t cur, input logic [ROOT_W-1:0] r);
        dv_t             nxt;
        logic [ROOT_W:0] t;
        t      = {cur.rem, cur.sr[Q_W-1]};
        nxt.sr = cur.sr << 1;
        if (t >= {1'b0, r}) begin
            nxt.rem   = ROOT_W'(t - {1'b0, r});
            nxt.sr[0] = 1'b1;
        end else begin
            nxt.rem   = t[ROOT_W-1:0];
            nxt.sr[0] = 1'b0;
        end
        return nxt;
    endfunction

    // stage 0: magnitudes and largest one
    logic                    v0_reg;
    side_t                   sd0_reg;
    logic [2:0][VEC_W-1:0]   mag0_reg;
    logic [VEC_W-1:0]        max0_reg;
    logic [2:0][VEC_W-1:0]   mag_c;
    logic [2:0]              neg_c;
    logic [VEC_W-1:0]        max_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_c[i] = in_vec[i][VEC_W-1];
            mag_c[i] = neg_c[i] ? (~in_vec[i] + VEC_W'(1)) : in_vec[i];
        end
        max_c = mag_c[0];
        if (mag_c[1] > max_c) begin
            max_c = mag_c[1];
        end
        if (mag_c[2] > max_c) begin
            max_c = mag_c[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
        if (en) begin
            sd0_reg.tag  <= in_tag;
            sd0_reg.neg  <= neg_c;
            sd0_reg.zero <= 1'b0;
            mag0_reg     <= mag_c;
            max0_reg     <= max_c;
        end
    end

    // stage 1: leading one of the largest magnitude
    logic                  v1_reg;
    side_t                 sd1_reg;
    logic [2:0][VEC_W-1:0] mag1_reg;
    logic [POS_W-1:0]      pos1_reg;
    logic [POS_W-1:0]      pos_c;

    always_comb begin
        pos_c = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (max0_reg[i]) begin
                pos_c = POS_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
        if (en) begin
            sd1_reg.tag  <= sd0_reg.tag;
            sd1_reg.neg  <= sd0_reg.neg;
            sd1_reg.zero <= (max0_reg == '0);
            mag1_reg     <= mag0_reg;
            pos1_reg     <= pos_c;
        end
    end

    // stage 2: bring the largest magnitude into [2^19, 2^20)
    logic             v2_reg;
    side_t            sd2_reg;
    nrm3_t            nm2_reg;
    nrm3_t            nm_c;
    logic [POS_W-1:0] rsh;
    logic [POS_W-1:0] lsh;
    logic [VEC_W-1:0] shifted;

    always_comb begin
        rsh = pos1_reg - POS_W'(NRM_W - 1);
        lsh = POS_W'(NRM_W - 1) - pos1_reg;
        for (int i = 0; i < 3; i++) begin
            if (pos1_reg >= POS_W'(NRM_W)) begin
                shifted = mag1_reg[i] >> rsh;
            end else begin
                shifted = mag1_reg[i] << lsh;
            end
            nm_c[i] = shifted[NRM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            sd2_reg <= sd1_reg;
            nm2_reg <= nm_c;
        end
    end

    // stage 3: squares
    logic                 v3_reg;
    side_t                sd3_reg;
    nrm3_t                nm3_reg;
    logic [2:0][SQ_W-1:0] sq3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            sd3_reg <= sd2_reg;
            nm3_reg <= nm2_reg;
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= SQ_W'(nm2_reg[i]) * SQ_W'(nm2_reg[i]);
            end
        end
    end

    // stage 4: radicand
    logic             v4_reg;
    side_t            sd4_reg;
    nrm3_t            nm4_reg;
    logic [RAD_W-1:0] rad4_reg;
    logic [N2_W-1:0]  n2_c;

    assign n2_c = N2_W'(sq3_reg[0]) + N2_W'(sq3_reg[1]) + N2_W'(sq3_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            sd4_reg  <= sd3_reg;
            nm4_reg  <= nm3_reg;
            rad4_reg <= RAD_W'(n2_c) << RAD_SHIFT;
        end
    end

    // square root, two result bits per stage
    logic  sv_reg [SQRT_STAGES+1];
    side_t ssd_reg [SQRT_STAGES+1];
    nrm3_t snm_reg [SQRT_STAGES+1];
    sq_t   sq_reg [SQRT_STAGES+1];

    always_comb begin
        sv_reg[0]     = v4_reg;
        ssd_reg[0]    = sd4_reg;
        snm_reg[0]    = nm4_reg;
        sq_reg[0].n   = rad4_reg;
        sq_reg[0].res = '0;
    end

    for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
        localparam int J0 = SQRT_STEPS + 1 - 2 * k;
        localparam int J1 = SQRT_STEPS - 2 * k;
        sq_t sq_next;

        always_comb begin
            sq_next = sqrt_step(sq_reg[k-1], J0);
            if (J1 >= 0) begin
                sq_next = sqrt_step(sq_next, J1);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k] <= 1'b0;
            end else if (en) begin
                sv_reg[k] <= sv_reg[k-1];
            end
            if (en) begin
                ssd_reg[k] <= ssd_reg[k-1];
                snm_reg[k] <= snm_reg[k-1];
                sq_reg[k]  <= sq_next;
            end
        end
    end

    // divider load: rounded numerator per component
    logic              root;
    logic [ROOT_W-1:0] root_c;
    logic [NUM_W-1:0]  num_c [3];

    assign root_c = sq_reg[SQRT_STAGES].res[ROOT_W-1:0];
    assign root   = sv_reg[SQRT_STAGES];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (frac_hi) begin
                num_c[i] = (NUM_W'(snm_reg[SQRT_STAGES][i]) << SHIFT_HI)
                         + NUM_W'(root_c >> 1);
            end else begin
                num_c[i] = (NUM_W'(snm_reg[SQRT_STAGES][i]) << SHIFT_LO)
                         + NUM_W'(root_c >> 1);
            end
        end
    end

    logic              dvv_reg [DIV_STAGES+1];
    side_t             dsd_reg [DIV_STAGES+1];
    logic [ROOT_W-1:0] dr_reg  [DIV_STAGES+1];
    dv_t               dv_reg  [DIV_STAGES+1][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvv_reg[0] <= 1'b0;
        end else if (en) begin
            dvv_reg[0] <= root;
        end
        if (en) begin
            dsd_reg[0] <= ssd_reg[SQRT_STAGES];
            dr_reg[0]  <= root_c;
            for (int i = 0; i < 3; i++) begin
                dv_reg[0][i].rem <= ROOT_W'(num_c[i] >> Q_W);
                dv_reg[0][i].sr  <= num_c[i][Q_W-1:0];
            end
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        localparam int S1 = 2 * k - 1;
        dv_t dv_next [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                dv_next[i] = div_step(dv_reg[k-1][i], dr_reg[k-1]);
                if (S1 < DIV_STEPS) begin
                    dv_next[i] = div_step(dv_next[i], dr_reg[k-1]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvv_reg[k] <= 1'b0;
            end else if (en) begin
                dvv_reg[k] <= dvv_reg[k-1];
            end
            if (en) begin
                dsd_reg[k] <= dsd_reg[k-1];
                dr_reg[k]  <= dr_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    dv_reg[k][i] <= dv_next[i];
                end
            end
        end
    end

    // sign back on, zero vector answers zero
    logic   out_valid_reg;
    tag_t   out_tag_reg;
    unit3_t out_vec_reg;
    side_t  last_sd;

    assign last_sd = dsd_reg[DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dvv_reg[DIV_STAGES];
        end
        if (en) begin
            out_tag_reg <= last_sd.tag;
            for (int i = 0; i < 3; i++) begin
                if (last_sd.zero) begin
                    out_vec_reg[i] <= '0;
                end else if (last_sd.neg[i]) begin
                    out_vec_reg[i] <= UNIT_W'(0) - UNIT_W'(dv_reg[DIV_STAGES][i].sr);
                end else begin
                    out_vec_reg[i] <= UNIT_W'(dv_reg[DIV_STAGES][i].sr);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_vec   = out_vec_reg;

endmodule

### sv/heightmap_normal_estimator_core.sv
// ----------------------------------------------------------------------------
// heightmap_normal_estimator_core
// Surface normal of a heightmap point from its four neighbours, Q2.14 out.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the two-entry output queue has room;
// the latency of a result is set by the two
// normalizer pipelines (39 stages each: 16 square root stages and 16 divider
// stages at two bits per stage) plus the height, scale and face sum stages.
// The pipeline halts as a whole only when the output queue is full.
// Registers may be written only while no request is in flight.
module heightmap_normal_estimator_core
    import hne_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [COORD_BITS-1:0]  s_pos_x,
    input  logic [COORD_BITS-1:0]  s_pos_z,
    input  logic [PIX_W-1:0]       s_center_pixel,
    input  logic [PIX_W-1:0]       s_left_pixel,
    input  logic [PIX_W-1:0]       s_up_pixel,
    input  logic [PIX_W-1:0]       s_right_pixel,
    input  logic [PIX_W-1:0]       s_down_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [OUT_W-1:0] m_normal_x,
    output logic signed [OUT_W-1:0] m_normal_y,
    output logic signed [OUT_W-1:0] m_normal_z,
    output logic                   m_on_border,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    function automatic logic [BSUM_W-1:0] byte_sum(input logic [PIX_W-1:0] w,
                                                   input logic [BPP_W-1:0] n);
        logic [BSUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (BPP_W'(i) < n) begin
                s = s + BSUM_W'(w[8*i +: 8]);
            end
        end
        return s;
    endfunction

    // configuration
    logic [SCALE_W-1:0] plane_scale_reg;
    logic [SCALE_W-1:0] height_scale_reg;
    logic [DIM_W-1:0]   map_width_reg;
    logic [DIM_W-1:0]   map_height_reg;
    logic [BPP_W-1:0]   bpp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_scale_reg  <= SCALE_W'(256);
            height_scale_reg <= SCALE_W'(256);
            map_width_reg    <= DIM_W'(256);
            map_height_reg   <= DIM_W'(256);
            bpp_reg          <= BPP_W'(1);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PLANE_SCALE:     plane_scale_reg  <= cfg_data;
                REG_HEIGHT_SCALE:    height_scale_reg <= cfg_data;
                REG_MAP_WIDTH:       map_width_reg    <= cfg_data[DIM_W-1:0];
                REG_MAP_HEIGHT:      map_height_reg   <= cfg_data[DIM_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg          <= cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // output queue and global advance
    result_t    q_mem_reg [2];
    logic       q_wr_reg;
    logic       q_rd_reg;
    logic [1:0] q_cnt_reg;
    logic       en;

    assign en      = (q_cnt_reg != 2'd2);
    assign s_ready = en;

    // stage A: byte sums, border test, plane scale
    logic              bpp_ok;
    logic [BPP_W-1:0]  n_bytes;
    logic [BPP_W-1:0]  k_fac;
    logic [PLANE_W-1:0] p_c;
    logic              border_c;

    always_comb begin
        bpp_ok   = bpp_reg inside {[3'd1:3'd4]};
        n_bytes  = bpp_ok ? bpp_reg : '0;
        k_fac    = bpp_ok ? bpp_reg : BPP_W'(1);
        p_c      = PLANE_W'(plane_scale_reg) * PLANE_W'(k_fac);
        border_c = !((s_pos_x != '0) && (s_pos_z != '0)
                  && (CMP_W'(s_pos_x) + CMP_W'(1) < CMP_W'(map_width_reg))
                  && (CMP_W'(s_pos_z) + CMP_W'(1) < CMP_W'(map_height_reg)));
    end

    logic                    sa_valid_reg;
    tag_t                    sa_tag_reg;
    logic [PLANE_W-1:0]      sa_p_reg;
    logic [4:0][BSUM_W-1:0]  sa_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
        end else if (en) begin
            sa_valid_reg <= s_valid;
        end
        if (en) begin
            sa_tag_reg.border   <= border_c;
            sa_tag_reg.force_up <= border_c || (p_c == '0);
            sa_p_reg            <= p_c;
            sa_sum_reg[0]       <= byte_sum(s_center_pixel, n_bytes);
            sa_sum_reg[1]       <= byte_sum(s_left_pixel, n_bytes);
            sa_sum_reg[2]       <= byte_sum(s_up_pixel, n_bytes);
            sa_sum_reg[3]       <= byte_sum(s_right_pixel, n_bytes);
            sa_sum_reg[4]       <= byte_sum(s_down_pixel, n_bytes);
        end
    end

    // stage B: scaled height differences to left, up, right, down
    logic                   sb_valid_reg;
    tag_t                   sb_tag_reg;
    logic [PLANE_W-1:0]     sb_p_reg;
    logic [3:0][HGT_W-1:0]  sb_hd_reg;
    logic signed [DIFF_W-1:0] diff_c [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            diff_c[i] = $signed(DIFF_W'(sa_sum_reg[0])) - $signed(DIFF_W'(sa_sum_reg[i+1]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_valid_reg <= 1'b0;
        end else if (en) begin
            sb_valid_reg <= sa_valid_reg;
        end
        if (en) begin
            sb_tag_reg <= sa_tag_reg;
            sb_p_reg   <= sa_p_reg;
            for (int i = 0; i < 4; i++) begin
                sb_hd_reg[i] <= HGT_W'(HGT_W'(diff_c[i])
                              * $signed(HGT_W'({1'b0, height_scale_reg})));
            end
        end
    end

    // faces: (-a,p,-b) (c,p,-b) (c,p,d) (-a,p,d)
    logic [VEC_W-1:0] ext_hd [4];
    logic [VEC_W-1:0] neg_a;
    logic [VEC_W-1:0] neg_b;
    logic [VEC_W-1:0] p_ext;
    vec3_t            face [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ext_hd[i] = {{(VEC_W-HGT_W){sb_hd_reg[i][HGT_W-1]}}, sb_hd_reg[i]};
        end
        neg_a = VEC_W'(0) - ext_hd[0];
        neg_b = VEC_W'(0) - ext_hd[1];
        p_ext = VEC_W'(sb_p_reg);
        face[0] = {neg_b,     p_ext, neg_a};
        face[1] = {neg_b,     p_ext, ext_hd[2]};
        face[2] = {ext_hd[3], p_ext, ext_hd[2]};
        face[3] = {ext_hd[3], p_ext, neg_a};
    end

    logic   fu_valid;
    tag_t   fu_tag;
    unit3_t fu_vec [4];

    hne_unit_vec u_face0 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .frac_hi(1'b1),
        .in_valid(sb_valid_reg), .in_tag(sb_tag_reg), .in_vec(face[0]),
        .out_valid(fu_valid), .out_tag(fu_tag), .out_vec(fu_vec[0])
    );

    for (genvar f = 1; f < 4; f++) begin : g_face
        hne_unit_vec u_face (
            .aclk(aclk), .aresetn(aresetn), .en(en), .frac_hi(1'b1),
            .in_valid(sb_valid_reg), .in_tag(sb_tag_reg), .in_vec(face[f]),
            .out_valid(), .out_tag(), .out_vec(fu_vec[f])
        );
    end

    // stage C: sum of the four face normals
    logic       sc_valid_reg;
    tag_t       sc_tag_reg;
    vec3_t      sc_sum_reg;
    logic signed [SUM_W-1:0] fsum_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fsum_c[i] = SUM_W'($signed(fu_vec[0][i])) + SUM_W'($signed(fu_vec[1][i]))
                      + SUM_W'($signed(fu_vec[2][i])) + SUM_W'($signed(fu_vec[3][i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
        end else if (en) begin
            sc_valid_reg <= fu_valid;
        end
        if (en) begin
            sc_tag_reg <= fu_tag;
            for (int i = 0; i < 3; i++) begin
                sc_sum_reg[i] <= {{(VEC_W-SUM_W){fsum_c[i][SUM_W-1]}}, fsum_c[i]};
            end
        end
    end

    logic   fin_valid;
    tag_t   fin_tag;
    unit3_t fin_vec;

    hne_unit_vec u_final (
        .aclk(aclk), .aresetn(aresetn), .en(en), .frac_hi(1'b0),
        .in_valid(sc_valid_reg), .in_tag(sc_tag_reg), .in_vec(sc_sum_reg),
        .out_valid(fin_valid), .out_tag(fin_tag), .out_vec(fin_vec)
    );

    result_t res_c;

    always_comb begin
        res_c.border = fin_tag.border;
        if (fin_tag.force_up) begin
            res_c.x = '0;
            res_c.y = ONE_Q14;
            res_c.z = '0;
        end else begin
            res_c.x = fin_vec[0][OUT_W-1:0];
            res_c.y = fin_vec[1][OUT_W-1:0];
            res_c.z = fin_vec[2][OUT_W-1:0];
        end
    end

    logic push;
    logic pop;

    assign push = en && fin_valid;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                q_wr_reg <= !q_wr_reg;
            end
            if (pop) begin
                q_rd_reg <= !q_rd_reg;
            end
            case ({push, pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + 2'd1;
                2'b01:   q_cnt_reg <= q_cnt_reg - 2'd1;
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
        if (push) begin
            q_mem_reg[q_wr_reg] <= res_c;
        end
    end

    result_t head;

    assign head        = q_mem_reg[q_rd_reg];
    assign m_valid     = (q_cnt_reg != 2'd0);
    assign m_normal_x  = head.x;
    assign m_normal_y  = head.y;
    assign m_normal_z  = head.z;
    assign m_on_border = head.border;

endmodule

### sv/hne_checker.sv
// ----------------------------------------------------------------------------
// hne_checker
// Port level checks of the heightmap normal estimator, bound to the core.
// ----------------------------------------------------------------------------
module hne_checker
    import hne_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [COORD_BITS-1:0]   s_pos_x,
    input logic [COORD_BITS-1:0]   s_pos_z,
    input logic [PIX_W-1:0]        s_center_pixel,
    input logic [PIX_W-1:0]        s_left_pixel,
    input logic [PIX_W-1:0]        s_up_pixel,
    input logic [PIX_W-1:0]        s_right_pixel,
    input logic [PIX_W-1:0]        s_down_pixel,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_normal_x,
    input logic signed [OUT_W-1:0] m_normal_y,
    input logic signed [OUT_W-1:0] m_normal_z,
    input logic                    m_on_border,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [CFG_IDX_W-1:0]    cfg_index,
    input logic [CFG_DATA_W-1:0]   cfg_data
);

    // a stalled result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid
            && $stable({m_normal_x, m_normal_y, m_normal_z, m_on_border}))
        else $error("result changed while stalled");

    a_border_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_on_border |->
            m_normal_x == '0 && m_normal_y == ONE_Q14 && m_normal_z == '0)
        else $error("border result is not the up vector");

    // normals always point up and stay within unit range
    a_y_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_y >= 0 && m_normal_y <= ONE_Q14)
        else $error("normal y out of range");

    a_xz_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x >= NEG_ONE_Q14 && m_normal_x <= ONE_Q14
            && m_normal_z >= NEG_ONE_Q14 && m_normal_z <= ONE_Q14)
        else $error("normal x or z out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind heightmap_normal_estimator_core hne_checker u_hne_checker (.*);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the heightmap normal estimator. A directed table runs first: border
// points, flat ground, extreme pixels and register extremes. Random phases
// follow, with varied settings and sender and receiver idling. Every result is
// compared field by field with an in-order queue of predicted normals.
// ----------------------------------------------------------------------------
module testbench
    import hne_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] z;
        logic [PIX_W-1:0]      pix [5];
    } point_t;

    typedef enum {ROW_WRITE, ROW_POINT} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        point_t                pt;
        bit                    typed;
        result_t               want;
    } row_t;

    localparam int LATENCY_WAIT = 120;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [COORD_BITS-1:0]   s_pos_x = '0;
    logic [COORD_BITS-1:0]   s_pos_z = '0;
    logic [PIX_W-1:0]        s_center_pixel = '0;
    logic [PIX_W-1:0]        s_left_pixel = '0;
    logic [PIX_W-1:0]        s_up_pixel = '0;
    logic [PIX_W-1:0]        s_right_pixel = '0;
    logic [PIX_W-1:0]        s_down_pixel = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_normal_x;
    logic signed [OUT_W-1:0] m_normal_y;
    logic signed [OUT_W-1:0] m_normal_z;
    logic                    m_on_border;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // register copy
    bit [SCALE_W-1:0] plane_scale;
    bit [SCALE_W-1:0] height_scale;
    bit [DIM_W-1:0]   map_width;
    bit [DIM_W-1:0]   map_height;
    bit [BPP_W-1:0]   bytes_per_pixel;

    result_t normals_due [$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    row_t    rows [$];

    heightmap_normal_estimator_core uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic bit [63:0] isqrt(bit [63:0] n);
        bit [63:0] res = 0;
        bit [63:0] b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // scale to [2^19, 2^20) and round each component against the root
    function automatic void unitize(input longint v [3], input int frac, output longint u [3]);
        bit [63:0] mag [3];
        bit [63:0] m = 0;
        bit [63:0] n2 = 0;
        bit [63:0] r;
        bit [63:0] q;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            u = '{0, 0, 0};
            return;
        end
        while (m >= (64'd1 << 20)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 19)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) n2 += mag[i] * mag[i];
        r = isqrt(n2 << 20);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << (frac + 10)) + (r >> 1)) / r;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint byte_sum(logic [PIX_W-1:0] w, int n);
        longint s = 0;
        for (int i = 0; i < n; i++) s += w[8*i +: 8];
        return s;
    endfunction

    function automatic result_t surface_normal(point_t pt);
        result_t r;
        bit      ok = bytes_per_pixel >= 1 && bytes_per_pixel <= 4;
        int      n = ok ? bytes_per_pixel : 0;
        longint  p = longint'(plane_scale) * (ok ? bytes_per_pixel : 1);
        longint  sc;
        longint  a, b, c, d;
        longint  face [3];
        longint  unit [3];
        longint  total [3];
        longint  res [3];
        r = '{x: '0, y: ONE_Q14, z: '0, border: 1'b1};
        if (!(pt.x > 0 && pt.z > 0 && int'(pt.x) + 1 < int'(map_width)
              && int'(pt.z) + 1 < int'(map_height)))
            return r;
        r.border = 1'b0;
        if (p == 0) return r;
        sc = byte_sum(pt.pix[0], n);
        a = (sc - byte_sum(pt.pix[1], n)) * height_scale;
        b = (sc - byte_sum(pt.pix[2], n)) * height_scale;
        c = (sc - byte_sum(pt.pix[3], n)) * height_scale;
        d = (sc - byte_sum(pt.pix[4], n)) * height_scale;
        total = '{0, 0, 0};
        for (int f = 0; f < 4; f++) begin
            face[0] = (f == 0 || f == 3) ? -a : c;
            face[1] = p;
            face[2] = (f < 2) ? -b : d;
            unitize(face, UNIT_FRAC, unit);
            for (int j = 0; j < 3; j++) total[j] += unit[j];
        end
        unitize(total, OUT_FRAC, res);
        r.x = res[0][OUT_W-1:0];
        r.y = res[1][OUT_W-1:0];
        r.z = res[2][OUT_W-1:0];
        return r;
    endfunction

    task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (normals_due.size() == 0) begin
                $display("%0t result with no request outstanding", $realtime);
                error_count++;
            end else begin
                result_t w;
                w = normals_due.pop_front();
                if (m_normal_x !== w.x) report("normal_x", m_normal_x, w.x);
                if (m_normal_y !== w.y) report("normal_y", m_normal_y, w.y);
                if (m_normal_z !== w.z) report("normal_z", m_normal_z, w.z);
                if (m_on_border !== w.border) report("on_border", m_on_border, w.border);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        while (normals_due.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PLANE_SCALE:     plane_scale = data;
            REG_HEIGHT_SCALE:    height_scale = data;
            REG_MAP_WIDTH:       map_width = data[DIM_W-1:0];
            REG_MAP_HEIGHT:      map_height = data[DIM_W-1:0];
            REG_BYTES_PER_PIXEL: bytes_per_pixel = data[BPP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // valid is left high after acceptance; the next call reloads the payload
    task automatic send_point(point_t pt, bit typed, result_t want);
        result_t pred = surface_normal(pt);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pos_x        <= pt.x;
        s_pos_z        <= pt.z;
        s_center_pixel <= pt.pix[0];
        s_left_pixel   <= pt.pix[1];
        s_up_pixel     <= pt.pix[2];
        s_right_pixel  <= pt.pix[3];
        s_down_pixel   <= pt.pix[4];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        normals_due.insert(normals_due.size(), typed ? want : pred);
    endtask

    function automatic point_t flat_point(int x, int z, logic [PIX_W-1:0] v);
        point_t pt;
        pt.x = x;
        pt.z = z;
        foreach (pt.pix[i]) pt.pix[i] = v;
        return pt;
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        row_t r;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.data = data;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void add_point(point_t pt, bit typed, result_t want);
        row_t r;
        r.kind = ROW_POINT;
        r.pt = pt;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic point_t random_point();
        point_t pt;
        int     wmax = (map_width > 4097) ? 4095 : int'(map_width) - 2;
        int     hmax = (map_height > 4097) ? 4095 : int'(map_height) - 2;
        logic [PIX_W-1:0] base = $urandom();
        int     spread = $urandom_range(0, 3);
        pt.x = (wmax >= 1 && $urandom_range(0, 9) != 0) ? $urandom_range(1, wmax) : $urandom();
        pt.z = (hmax >= 1 && $urandom_range(0, 9) != 0) ? $urandom_range(1, hmax) : $urandom();
        foreach (pt.pix[i]) begin
            case (spread)
                0: pt.pix[i] = $urandom();
                1: pt.pix[i] = base ^ ($urandom() & 32'h0303_0303);
                2: pt.pix[i] = base ^ ($urandom() & 32'h0000_0001);
                default: pt.pix[i] = $urandom() & 32'h8080_8080;
            endcase
        end
        return pt;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick(int lo, int hi, int top);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return $urandom_range(0, top);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    initial begin
        result_t up_border;
        result_t up_flat;
        result_t none;
        point_t  pt;

        up_border = '{x: '0, y: ONE_Q14, z: '0, border: 1'b1};
        up_flat   = '{x: '0, y: ONE_Q14, z: '0, border: 1'b0};
        none      = '{x: '0, y: '0, z: '0, border: 1'b0};

        plane_scale = 256;
        height_scale = 256;
        map_width = 256;
        map_height = 256;
        bytes_per_pixel = 1;

        // border points, flat ground and slopes at reset settings
        add_point(flat_point(0, 10, 32'hFFFF_FFFF), 1, up_border);
        add_point(flat_point(10, 0, 32'h0), 1, up_border);
        add_point(flat_point(255, 10, 32'h1234_5678), 1, up_border);
        add_point(flat_point(10, 255, 32'h0), 1, up_border);
        add_point(flat_point(4095, 4095, 32'h0), 1, up_border);
        add_point(flat_point(1, 1, 32'hFFFF_FFFF), 1, up_flat);
        add_point(flat_point(253, 253, 32'h5A5A_5A5A), 1, up_flat);
        pt = flat_point(5, 5, 32'h0);
        pt.pix[0] = 32'hFFFF_FFFF;
        add_point(pt, 0, none);
        pt = flat_point(7, 9, 32'hFFFF_FFFF);
        pt.pix[0] = 32'h0;
        pt.pix[3] = 32'h0;
        add_point(pt, 0, none);
        // register extremes
        add_write(REG_BYTES_PER_PIXEL, 4);
        add_write(REG_HEIGHT_SCALE, 16'hFFFF);
        add_write(REG_PLANE_SCALE, 1);
        add_write(REG_MAP_WIDTH, 4096);
        add_write(REG_MAP_HEIGHT, 4096);
        add_point(pt, 0, none);
        add_point(flat_point(4094, 4094, 32'hAAAA_5555), 1, up_flat);
        add_point(flat_point(4095, 1, 32'h0), 1, up_border);
        add_write(REG_PLANE_SCALE, 0);
        add_point(pt, 1, up_flat);
        add_write(REG_PLANE_SCALE, 16'hFFFF);
        add_write(REG_HEIGHT_SCALE, 0);
        add_point(pt, 1, up_flat);
        add_write(REG_BYTES_PER_PIXEL, 7);
        add_write(REG_HEIGHT_SCALE, 300);
        add_point(pt, 1, up_flat);
        add_write(REG_BYTES_PER_PIXEL, 0);
        add_point(pt, 1, up_flat);
        add_write(REG_MAP_WIDTH, 16'hFFFF);
        add_write(REG_MAP_HEIGHT, 1);
        add_point(flat_point(1, 1, 32'h0), 1, up_border);
        add_write(REG_MAP_HEIGHT, 0);
        add_point(flat_point(2, 2, 32'h0), 1, up_border);
        add_write(REG_MAP_HEIGHT, 3);
        add_write(REG_MAP_WIDTH, 3);
        add_write(REG_BYTES_PER_PIXEL, 2);
        pt.x = 1;
        pt.z = 1;
        add_point(pt, 0, none);
        // indexes past the register list are ignored
        add_write(3'd5, 16'h0);
        add_write(3'd6, 16'hFFFF);
        add_write(3'd7, 16'h0);
        add_point(pt, 0, none);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                if (s_valid) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                end
                wait_drained();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send_point(rows[i].pt, rows[i].typed, rows[i].want);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            if (s_valid) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            write_reg(REG_PLANE_SCALE, pick(1, 65535, 65535));
            write_reg(REG_HEIGHT_SCALE, pick(0, 65535, 65535));
            write_reg(REG_MAP_WIDTH, pick(3, 4096, 8191));
            write_reg(REG_MAP_HEIGHT, pick(3, 4096, 8191));
            write_reg(REG_BYTES_PER_PIXEL, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(0, 7) : $urandom_range(1, 4));
            for (int k = 0; k < 92; k++) begin
                // hold off once, midway through phase 3, until the pipeline has emptied
                if (ph == 3 && k == 46) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (normals_due.size() != 0) @(posedge aclk);
                end
                send_point(random_point(), 0, none);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
